[rtl/core/sfb_pkg.sv]
// Package for the serial frame builder with checksum.
// Holds the channel payload types, the item record passed to the result
// sequencer, the frame constants and the register index codes. No dependencies.
package sfb_pkg;

  // Frame constants.
  localparam logic [7:0] HEAD0        = 8'hA6;
  localparam logic [7:0] HEAD1        = 8'h59;
  localparam logic [7:0] TAIL0        = 8'h59;  // 'Y'
  localparam logic [7:0] TAIL1        = 8'h48;  // 'H'
  localparam logic [7:0] TAIL2        = 8'h54;  // 'T'
  localparam logic [7:0] LEN_OVERHEAD = 8'd11;
  localparam logic [7:0] MAX_PAYLOAD  = 8'd64;
  localparam logic [7:0] MIN_PAYLOAD  = 8'd2;
  localparam logic [7:0] CFG_RESET    = 8'd1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_NODE_ID    = 2'd0;
  localparam logic [1:0] CFG_COMMAND_ID = 2'd1;
  localparam logic [1:0] CFG_TARGET_REG = 2'd2;

  // Kinds of accepted item, which set how many results it produces.
  localparam logic [1:0] KIND_ERROR  = 2'd0;  // one error result
  localparam logic [1:0] KIND_HEADER = 2'd1;  // six header bytes and the data byte
  localparam logic [1:0] KIND_MIDDLE = 2'd2;  // the data byte alone
  localparam logic [1:0] KIND_LAST   = 2'd3;  // data byte, checksum and tail

  // Result index of the last result of each kind.
  localparam logic [2:0] LAST_IDX_ERROR  = 3'd0;
  localparam logic [2:0] LAST_IDX_HEADER = 3'd6;
  localparam logic [2:0] LAST_IDX_MIDDLE = 3'd0;
  localparam logic [2:0] LAST_IDX_LAST   = 3'd5;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] payload_length;
  } sfb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       length_error;
    logic       run_last;
  } sfb_out_t;

  // Everything the sequencer needs to emit the results of one request.
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [7:0]  length_byte;
    logic [7:0]  node_id;
    logic [7:0]  command_id;
    logic [7:0]  target_reg;
    logic [15:0] checksum;
  } sfb_item_t;

endpackage

[rtl/core/sfb_emit.sv]
// Result sequencer of the serial frame builder: holds one item record and
// emits its results one per cycle on the output channel while it is not stalled.
// Depends on sfb_pkg.
module sfb_emit import sfb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  sfb_item_t item,
  output logic      done,
  output logic      busy,
  output logic      result_valid,
  input  logic      result_stall,
  output sfb_out_t  result
);

  sfb_item_t  held;
  logic       valid;
  logic [2:0] idx;
  logic [2:0] idx_next;
  logic [2:0] last_idx;
  logic       at_last;
  logic       take;

  // Index of the last result of the held item.
  always_comb begin
    case (held.kind)
      KIND_ERROR:  last_idx = LAST_IDX_ERROR;
      KIND_HEADER: last_idx = LAST_IDX_HEADER;
      KIND_MIDDLE: last_idx = LAST_IDX_MIDDLE;
      KIND_LAST:   last_idx = LAST_IDX_LAST;
      default:     last_idx = LAST_IDX_ERROR;
    endcase
  end

  assign at_last  = (idx == last_idx);
  assign take     = valid && !result_stall;
  assign done     = take && at_last;
  assign busy     = valid;
  assign idx_next = idx + 3'd1;

  // Item register and result counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 3'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 3'd0;
    end else if (done) begin
      valid <= 1'b0;
      idx   <= 3'd0;
    end else if (take) begin
      idx <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= item;
    end
  end

  // Select the byte for the current result.
  always_comb begin
    result.out_byte     = 8'd0;
    result.frame_end    = 1'b0;
    result.length_error = 1'b0;
    result.run_last     = at_last;
    case (held.kind)
      KIND_ERROR: begin
        result.length_error = 1'b1;
      end
      KIND_HEADER: begin
        case (idx)
          3'd0:    result.out_byte = HEAD0;
          3'd1:    result.out_byte = HEAD1;
          3'd2:    result.out_byte = held.length_byte;
          3'd3:    result.out_byte = held.node_id;
          3'd4:    result.out_byte = held.command_id;
          3'd5:    result.out_byte = held.target_reg;
          default: result.out_byte = held.data_byte;
        endcase
      end
      KIND_MIDDLE: begin
        result.out_byte = held.data_byte;
      end
      KIND_LAST: begin
        case (idx)
          3'd0:    result.out_byte = held.data_byte;
          3'd1:    result.out_byte = held.checksum[15:8];
          3'd2:    result.out_byte = held.checksum[7:0];
          3'd3:    result.out_byte = TAIL0;
          3'd4:    result.out_byte = TAIL1;
          default: begin
            result.out_byte  = TAIL2;
            result.frame_end = 1'b1;
          end
        endcase
      end
      default: result.length_error = 1'b1;
    endcase
  end

  assign result_valid = valid;

  // The counter never runs past the last result of the held item.
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> (idx <= last_idx))
    else $error("result index beyond item's last result");

  // An error result and the tail end are always the last result of their item.
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (valid && (result.length_error || result.frame_end)) |-> result.run_last)
    else $error("error or frame end not marked as last result");

  // Finishing an item with no new load leaves the sequencer empty.
  a_done_empties: assert property (@(posedge clk) disable iff (rst)
    (done && !load) |=> !valid)
    else $error("sequencer still busy after its last result");

  // A new item is loaded only when the previous one is finished.
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!valid || done))
    else $error("item loaded over an unfinished one");

endmodule

[rtl/core/serial_frame_builder_with_sum.sv]
// Serial frame builder with 16-bit additive checksum: top level.
// The first result of a request appears in the cycle after it is accepted.
// Throughput: one result per cycle if not stalled; a request makes 1 result (middle
// byte or length error), 7 (header with first byte) or 6 (last byte, checksum and
// tail), so middle bytes flow at one per cycle, set by the one-result sequencer.
// Reset (synchronous): frame state cleared, registers set to 1, no result pending.
module serial_frame_builder_with_sum import sfb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  sfb_in_t    item,
  output logic       result_valid,
  input  logic       result_stall,
  output sfb_out_t   result,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic [7:0]  node_id;
  logic [7:0]  command_id;
  logic [7:0]  target_reg;
  logic [6:0]  bytes_remaining;
  logic [6:0]  bytes_remaining_next;
  logic [15:0] running_sum;
  logic [15:0] running_sum_next;
  logic [15:0] header_sum;
  logic [15:0] cont_sum;
  logic [7:0]  length_byte;
  logic [6:0]  rem_dec;
  logic        length_bad;
  logic        accept;
  logic        done;
  logic        busy;
  sfb_item_t   rec;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_id    <= CFG_RESET;
      command_id <= CFG_RESET;
      target_reg <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_ID:    node_id    <= cfg_wdata;
        CFG_COMMAND_ID: command_id <= cfg_wdata;
        CFG_TARGET_REG: target_reg <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // A request enters whenever the sequencer is empty or finishing.
  assign item_stall = busy && !done;
  assign accept     = item_valid && !item_stall;

  // Frame arithmetic for the incoming byte.
  assign length_byte = item.payload_length + LEN_OVERHEAD;
  assign length_bad  = (item.payload_length < MIN_PAYLOAD) ||
                       (item.payload_length > MAX_PAYLOAD);
  assign header_sum  = {8'd0, HEAD0} + {8'd0, HEAD1} + {8'd0, length_byte} +
                       {8'd0, node_id} + {8'd0, command_id} +
                       {8'd0, target_reg} + {8'd0, item.data_byte};
  assign cont_sum    = running_sum + {8'd0, item.data_byte};
  assign rem_dec     = bytes_remaining - 7'd1;

  // Build the item record and the next frame state.
  always_comb begin
    rec.data_byte        = item.data_byte;
    rec.length_byte      = length_byte;
    rec.node_id          = node_id;
    rec.command_id       = command_id;
    rec.target_reg       = target_reg;
    rec.checksum         = cont_sum;
    rec.kind             = KIND_MIDDLE;
    bytes_remaining_next = bytes_remaining;
    running_sum_next     = running_sum;
    if (bytes_remaining == 7'd0) begin
      if (length_bad) begin
        rec.kind = KIND_ERROR;
      end else begin
        rec.kind             = KIND_HEADER;
        bytes_remaining_next = 7'(item.payload_length - 8'd1);
        running_sum_next     = header_sum;
      end
    end else begin
      bytes_remaining_next = rem_dec;
      if (rem_dec == 7'd0) begin
        rec.kind         = KIND_LAST;
        running_sum_next = 16'd0;
      end else begin
        rec.kind         = KIND_MIDDLE;
        running_sum_next = cont_sum;
      end
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= 7'd0;
      running_sum     <= 16'd0;
    end else if (accept) begin
      bytes_remaining <= bytes_remaining_next;
      running_sum     <= running_sum_next;
    end
  end

  sfb_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .item         (rec),
    .done         (done),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  // Bytes still expected never exceed the largest payload.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, bytes_remaining} < MAX_PAYLOAD))
    else $error("bytes remaining beyond maximum payload");

  // The sum is cleared between frames.
  a_sum_idle: assert property (@(posedge clk) disable iff (rst)
    (bytes_remaining == 7'd0) |-> (running_sum == 16'd0))
    else $error("running sum not cleared between frames");

  // A rejected length leaves the block awaiting a frame start.
  a_err_keeps_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && rec.kind == KIND_ERROR) |=> (bytes_remaining == 7'd0))
    else $error("frame started on a rejected length");

endmodule

[verif/tb_serial_frame_builder_with_sum.sv]
// Self-checking testbench for serial_frame_builder_with_sum.
// Drives payload bytes and register writes, predicts every framed byte and checks it.
// Depends on sfb_pkg and the serial_frame_builder_with_sum top level.
import sfb_pkg::*;

// Tracks the frame being built and holds the bytes the block still owes us.
class framed_stream_check;
  logic [7:0]  node_id;
  logic [7:0]  command_id;
  logic [7:0]  target_reg;
  logic [6:0]  bytes_left;
  logic [15:0] frame_sum;
  sfb_out_t    awaited[$];
  int          mismatches;

  function new();
    node_id    = CFG_RESET;
    command_id = CFG_RESET;
    target_reg = CFG_RESET;
    bytes_left = '0;
    frame_sum  = '0;
    mismatches = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [7:0] value);
    case (idx)
      CFG_NODE_ID:    node_id = value;
      CFG_COMMAND_ID: command_id = value;
      CFG_TARGET_REG: target_reg = value;
      default: ;
    endcase
  endfunction

  function void add(logic [7:0] b, logic at_end, logic err, logic is_final);
    sfb_out_t r;
    r.out_byte     = b;
    r.frame_end    = at_end;
    r.length_error = err;
    r.run_last     = is_final;
    awaited.push_back(r);
  endfunction

  // Stream bytes up to and including the payload count toward the checksum.
  function void add_summed(logic [7:0] b, logic is_final);
    frame_sum = frame_sum + 16'(b);
    add(b, 1'b0, 1'b0, is_final);
  endfunction

  function void log_request(sfb_in_t req);
    logic [7:0] length_byte;
    if (bytes_left == 0) begin
      // A frame start with a length of zero, one or above the maximum is refused.
      if (req.payload_length < MIN_PAYLOAD || req.payload_length > MAX_PAYLOAD) begin
        add(8'h00, 1'b0, 1'b1, 1'b1);
        return;
      end
      length_byte = req.payload_length + LEN_OVERHEAD;
      frame_sum = '0;
      add_summed(HEAD0, 1'b0);
      add_summed(HEAD1, 1'b0);
      add_summed(length_byte, 1'b0);
      add_summed(node_id, 1'b0);
      add_summed(command_id, 1'b0);
      add_summed(target_reg, 1'b0);
      add_summed(req.data_byte, 1'b1);
      bytes_left = 7'(req.payload_length - 8'd1);
    end else begin
      // Later bytes pass through; the last one also releases checksum and tail.
      bytes_left = bytes_left - 7'd1;
      add_summed(req.data_byte, bytes_left != 0);
      if (bytes_left == 0) begin
        add(frame_sum[15:8], 1'b0, 1'b0, 1'b0);
        add(frame_sum[7:0], 1'b0, 1'b0, 1'b0);
        add(TAIL0, 1'b0, 1'b0, 1'b0);
        add(TAIL1, 1'b0, 1'b0, 1'b0);
        add(TAIL2, 1'b1, 1'b0, 1'b1);
        frame_sum = '0;
      end
    end
  endfunction

  function void check_output(sfb_out_t got);
    sfb_out_t want;
    if (awaited.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result, expected none, got byte %h end %b err %b last %b",
               $time, got.out_byte, got.frame_end, got.length_error, got.run_last);
      return;
    end
    want = awaited.pop_front();
    if (got.out_byte !== want.out_byte || got.frame_end !== want.frame_end ||
        got.length_error !== want.length_error || got.run_last !== want.run_last) begin
      mismatches++;
      $display("%0t: expected byte %h end %b err %b last %b, got byte %h end %b err %b last %b",
               $time, want.out_byte, want.frame_end, want.length_error, want.run_last,
               got.out_byte, got.frame_end, got.length_error, got.run_last);
    end
  endfunction
endclass

module tb_serial_frame_builder_with_sum;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 160;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  sfb_in_t    item         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  sfb_out_t   result;
  logic       cfg_we       = 1'b0;
  logic [1:0] cfg_index    = CFG_NODE_ID;
  logic [7:0] cfg_wdata    = '0;

  framed_stream_check tracker = new();

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int sent_count  = 0;
  int idle_cycles = 0;
  bit hold_armed  = 1'b0;

  serial_frame_builder_with_sum dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Output side: random stalls, or one long hold-off when armed.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // Handshakes are sampled mid-cycle, where every signal has settled.
  always @(negedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (item_valid && !item_stall) begin
        tracker.log_request(item);
        idle_cycles = 0;
      end
      if (result_valid && !result_stall) begin
        tracker.check_output(result);
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offers one request and returns at the edge that accepts it.
  task automatic send_request(input logic [7:0] data, input logic [7:0] len);
    sfb_in_t req;
    req.data_byte      = data;
    req.payload_length = len;
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    do @(negedge clk); while (item_stall);
    @(posedge clk);
    sent_count++;
  endtask

  // Length field is random on every byte after the first, where it is ignored.
  task automatic send_frame(input int len, input bit flood);
    for (int i = 0; i < len; i++)
      send_request(flood ? 8'hFF : 8'($urandom_range(255)),
                   (i == 0) ? 8'(len) : 8'($urandom_range(255)));
  endtask

  // A frame start whose length is refused.
  task automatic send_bad_start();
    int pick;
    pick = $urandom_range(3);
    send_request(8'($urandom_range(255)),
                 (pick == 0) ? 8'd0 : (pick == 1) ? 8'd1 : 8'($urandom_range(255, 65)));
  endtask

  task automatic run_random(input int goal);
    int first;
    int pick;
    first = sent_count;
    while (sent_count - first < goal) begin
      pick = $urandom_range(99);
      if (pick < 15)
        send_bad_start();
      else if (pick < 80)
        send_frame($urandom_range(8, 2), 1'b0);
      else if (pick < 95)
        send_frame($urandom_range(32, 9), 1'b0);
      else
        send_frame($urandom_range(64, 33), 1'b0);
    end
  endtask

  // Drops the input and waits until every owed result has come out.
  task automatic wait_drain();
    item_valid <= 1'b0;
    do @(negedge clk); while (tracker.awaited.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] node, input logic [7:0] cmd,
                              input logic [7:0] target);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NODE_ID;
    cfg_wdata <= node;
    @(posedge clk);
    tracker.write_reg(CFG_NODE_ID, node);
    cfg_index <= CFG_COMMAND_ID;
    cfg_wdata <= cmd;
    @(posedge clk);
    tracker.write_reg(CFG_COMMAND_ID, cmd);
    cfg_index <= CFG_TARGET_REG;
    cfg_wdata <= target;
    @(posedge clk);
    tracker.write_reg(CFG_TARGET_REG, target);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(input int tx_pct, input int rx_pct);
    @(negedge clk);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_idling(27, 55);

    // Directed: refused lengths, shortest frames, extreme bytes, reset registers.
    send_request(8'hFF, 8'd0);
    send_request(8'h00, 8'd1);
    send_request(8'hAA, 8'd65);
    send_request(8'h55, 8'd255);
    send_request(8'h00, 8'd2);
    send_request(8'hFF, 8'd0);
    send_request(8'hFF, 8'd3);
    send_request(8'h00, 8'd255);
    send_request(8'h5A, 8'd1);
    send_request(8'hA5, 8'd64);
    send_request(8'hFF, 8'd0);
    send_request(8'h00, 8'd1);
    send_request(8'hC3, 8'd200);
    wait_drain();

    // Sender idles less than the receiver, registers at their low extreme.
    program_regs(8'h00, 8'h00, 8'h00);
    run_random(PHASE_ITEMS);
    wait_drain();

    // Receiver idles less than the sender, registers at their high extreme.
    program_regs(8'hFF, 8'hFF, 8'hFF);
    set_idling(55, 27);
    run_random(PHASE_ITEMS);
    wait_drain();

    // No idling; a long output hold-off backs up a full-size frame first.
    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
    set_idling(0, 0);
    @(negedge clk);
    hold_armed = 1'b1;
    @(posedge clk);
    send_frame(64, 1'b1);
    run_random(PHASE_ITEMS);
    wait_drain();
    repeat (10) @(posedge clk);

    if (tracker.awaited.size() != 0)
      $display("%0t: %0d results never arrived", $time, tracker.awaited.size());
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/sfb_pkg.sv
rtl/core/sfb_emit.sv
rtl/core/serial_frame_builder_with_sum.sv
verif/tb_serial_frame_builder_with_sum.sv
